// ===== rtl/core/format_spec_parser_core_defines.svh =====
// Assertion macros shared by the format spec parser checker.
`ifndef FORMAT_SPEC_PARSER_CORE_DEFINES_SVH
`define FORMAT_SPEC_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define FSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/fsp_pkg.sv =====
// Types and constants of the format spec parser.
package fsp_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_out;
        logic       zero_fill;
        logic [7:0] field_width;
        logic [7:0] field_precision;
        logic [1:0] error_code;
        logic       end_of_format;
    } t_out_word;

    // parse states
    localparam logic [1:0] ST_TEXT  = 2'd0;
    localparam logic [1:0] ST_BEGIN = 2'd1;
    localparam logic [1:0] ST_SPEC  = 2'd2;

    typedef struct packed {
        logic [1:0] parse_state;
        logic       prec_mode;
        logic       zero_flag;
        logic       error_hold;
    } t_ctl;

    // result kinds
    localparam logic [1:0] KIND_LIT  = 2'd0;
    localparam logic [1:0] KIND_SPEC = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_PCT_END  = 2'd0;
    localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
    localparam logic [1:0] ERR_UNTERM   = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;

    localparam logic [7:0]  FIELD_MAX = 8'hFF;
    localparam int unsigned DEC_RADIX = 10;

endpackage

// ===== rtl/core/fsp_step.sv =====
// Next-state and result logic for one format character.
module fsp_step
    import fsp_pkg::*;
#(
    parameter int COUNT_BITS = 8
) (
    input  t_in_word              i_word,
    input  t_ctl                  i_ctl,
    input  logic [COUNT_BITS-1:0] i_width,
    input  logic [COUNT_BITS-1:0] i_prec,
    output t_ctl                  o_ctl,
    output logic [COUNT_BITS-1:0] o_width,
    output logic [COUNT_BITS-1:0] o_prec,
    output logic                  o_res_vld,
    output t_out_word             o_res
);

    localparam int ACCW = COUNT_BITS + 4;
    localparam int WIDE = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [ACCW-1:0] ACC_MAX = ACCW'({COUNT_BITS{1'b1}});

    logic                  is_digit;
    logic                  is_alpha;
    logic [COUNT_BITS-1:0] acc_src;
    logic [ACCW-1:0]       acc_sum;
    logic [COUNT_BITS-1:0] acc_sat;
    logic [WIDE-1:0]       w_ext;
    logic [WIDE-1:0]       p_ext;
    logic [7:0]            w_clip;
    logic [7:0]            p_clip;
    logic                  do_err;
    logic [1:0]            err_code;

    assign is_digit = (i_word.ch >= CH_ZERO) && (i_word.ch <= CH_NINE);
    assign is_alpha = ((i_word.ch >= CH_UP_A) && (i_word.ch <= CH_UP_Z)) ||
                      ((i_word.ch >= CH_LO_A) && (i_word.ch <= CH_LO_Z));

    // one shared x10 + digit, saturating
    assign acc_src = i_ctl.prec_mode ? i_prec : i_width;
    assign acc_sum = {4'b0000, acc_src} * ACCW'(DEC_RADIX) + ACCW'(i_word.ch[3:0]);
    assign acc_sat = (acc_sum > ACC_MAX) ? {COUNT_BITS{1'b1}}
                                         : acc_sum[COUNT_BITS-1:0];

    assign w_ext  = WIDE'(i_width);
    assign p_ext  = WIDE'(i_prec);
    assign w_clip = (w_ext > WIDE'(FIELD_MAX)) ? FIELD_MAX : w_ext[7:0];
    assign p_clip = (p_ext > WIDE'(FIELD_MAX)) ? FIELD_MAX : p_ext[7:0];

    always_comb begin
        o_ctl     = i_ctl;
        o_width   = i_width;
        o_prec    = i_prec;
        o_res_vld = 1'b0;
        do_err    = 1'b0;
        err_code  = ERR_PCT_END;
        o_res                 = '0;
        o_res.char_out        = i_word.ch;
        o_res.end_of_format   = i_word.last;

        priority if (i_ctl.error_hold) begin
            // drop everything up to the last character of the string
            if (i_word.last) begin
                o_ctl.error_hold  = 1'b0;
                o_ctl.parse_state = ST_TEXT;
                o_ctl.prec_mode   = 1'b0;
            end
        end else if (i_ctl.parse_state != ST_BEGIN && i_ctl.parse_state != ST_SPEC) begin
            o_ctl.parse_state = ST_TEXT;
            if (i_word.ch == CH_PERCENT) begin
                if (i_word.last) begin
                    do_err   = 1'b1;
                    err_code = ERR_PCT_END;
                end else begin
                    o_ctl.parse_state = ST_BEGIN;
                    o_ctl.prec_mode   = 1'b0;
                    o_ctl.zero_flag   = 1'b0;
                    o_width           = '0;
                    o_prec            = '0;
                end
            end else begin
                o_res_vld  = 1'b1;
                o_res.kind = KIND_LIT;
            end
        end else if (i_ctl.parse_state == ST_BEGIN && i_word.ch == CH_PERCENT) begin
            o_ctl.parse_state = ST_TEXT;
            o_res_vld         = 1'b1;
            o_res.kind        = KIND_LIT;
        end else if (i_ctl.parse_state == ST_BEGIN && i_word.ch == CH_ZERO) begin
            o_ctl.zero_flag   = 1'b1;
            o_ctl.parse_state = ST_SPEC;
            if (i_word.last) begin
                do_err   = 1'b1;
                err_code = ERR_UNTERM;
            end
        end else begin
            o_ctl.parse_state = ST_SPEC;
            priority if (i_word.ch == CH_DOT) begin
                o_ctl.prec_mode = 1'b1;
                if (i_word.last) begin
                    do_err   = 1'b1;
                    err_code = ERR_UNTERM;
                end
            end else if (is_digit) begin
                if (i_ctl.prec_mode) begin
                    o_prec = acc_sat;
                end else begin
                    o_width = acc_sat;
                end
                if (i_word.last) begin
                    do_err   = 1'b1;
                    err_code = ERR_UNTERM;
                end
            end else if (is_alpha) begin
                o_ctl.parse_state     = ST_TEXT;
                o_ctl.prec_mode       = 1'b0;
                o_res_vld             = 1'b1;
                o_res.kind            = KIND_SPEC;
                o_res.zero_fill       = i_ctl.zero_flag;
                o_res.field_width     = w_clip;
                o_res.field_precision = p_clip;
            end else begin
                do_err   = 1'b1;
                err_code = ERR_BAD_CHAR;
            end
        end

        if (do_err) begin
            o_ctl.parse_state = ST_TEXT;
            o_ctl.prec_mode   = 1'b0;
            o_ctl.error_hold  = ~i_word.last;
            o_res_vld         = 1'b1;
            o_res.kind        = KIND_ERR;
            o_res.error_code  = err_code;
        end
    end

endmodule

// ===== rtl/core/format_spec_parser_core.sv =====
// Format spec parser: printf-style format characters in, literal/spec/error words out.
//
// Input channel: i_in_valid / o_in_stall carry one character word (ch, last)
// per accepted cycle. Output channel: o_out_valid / i_out_stall carry a result
// word (literal character, completed specifier or error). A character makes
// zero or one result; a '%' that opens a specifier, digits and '.' that do not end
// the string, and characters dropped after an error make none.
// A word accepted into the input register is decoded by fsp_step into the output
// register, which drives o_out_valid. Throughput is one character per clock while
// the output is not held by a stall, set by the single decode stage between the two
// registers.
// Reset (synchronous, active low) empties both registers and returns the
// parser to free text with no error hold.
// When the receiver stalls, the output word holds; the input register still
// drains characters that make no result, and o_in_stall rises only once a
// result-bearing character waits behind the held output word.
module format_spec_parser_core
    import fsp_pkg::*;
#(
    parameter int COUNT_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic                  r_in_vld;
    t_in_word              r_in_word;
    logic                  r_out_vld;
    t_out_word             r_out_word;
    t_ctl                  r_ctl;
    logic [COUNT_BITS-1:0] r_width;
    logic [COUNT_BITS-1:0] r_prec;

    t_ctl                  n_ctl;
    logic [COUNT_BITS-1:0] n_width;
    logic [COUNT_BITS-1:0] n_prec;
    logic                  res_vld;
    t_out_word             res;

    logic out_free;
    logic s1_go;
    logic accept_in;

    fsp_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .i_word   (r_in_word),
        .i_ctl    (r_ctl),
        .i_width  (r_width),
        .i_prec   (r_prec),
        .o_ctl    (n_ctl),
        .o_width  (n_width),
        .o_prec   (n_prec),
        .o_res_vld(res_vld),
        .o_res    (res)
    );

    assign out_free   = ~r_out_vld | ~i_out_stall;
    assign s1_go      = r_in_vld & (~res_vld | out_free);
    assign o_in_stall = r_in_vld & ~s1_go;
    assign accept_in  = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ctl     <= '{parse_state: ST_TEXT, default: 1'b0};
            r_width   <= '0;
            r_prec    <= '0;
        end else begin
            if (accept_in) begin
                r_in_vld <= 1'b1;
            end else if (s1_go) begin
                r_in_vld <= 1'b0;
            end

            if (s1_go) begin
                r_ctl   <= n_ctl;
                r_width <= n_width;
                r_prec  <= n_prec;
            end

            if (s1_go && res_vld) begin
                r_out_vld <= 1'b1;
            end else if (out_free) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_word <= i_in_word;
        end
        if (s1_go && res_vld) begin
            r_out_word <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/core/fsp_checker.sv =====
// Port-level checker for the format spec parser, bound to the top level.
`include "format_spec_parser_core_defines.svh"

module fsp_checker
    import fsp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_stall,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_word i_out_word
);

    `FSP_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_word), "stalled output word changed")

    `FSP_ASSERT_NOW(a_in_stall_cause, i_in_stall, i_out_valid && i_out_stall, "input stalled while output can move")

    `FSP_ASSERT_NOW(a_lit_clean, i_out_valid && i_out_word.kind == KIND_LIT, i_out_word.zero_fill == 1'b0 && i_out_word.field_width == 8'h00 && i_out_word.field_precision == 8'h00 && i_out_word.error_code == ERR_PCT_END, "literal word carries spec fields")

    `FSP_ASSERT_NOW(a_spec_letter, i_out_valid && i_out_word.kind == KIND_SPEC, ((i_out_word.char_out >= CH_UP_A && i_out_word.char_out <= CH_UP_Z) || (i_out_word.char_out >= CH_LO_A && i_out_word.char_out <= CH_LO_Z)) && i_out_word.error_code == ERR_PCT_END, "spec word without letter command")

    `FSP_ASSERT_NOW(a_err_clean, i_out_valid && i_out_word.kind == KIND_ERR, i_out_word.zero_fill == 1'b0 && i_out_word.field_width == 8'h00 && i_out_word.field_precision == 8'h00, "error word carries spec fields")

endmodule

bind format_spec_parser_core fsp_checker u_fsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_stall (o_in_stall),
    .i_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .i_out_word (o_out_word)
);

// ===== tb/sv/tb.sv =====
// Testbench for format_spec_parser_core: directed and random format strings, scoreboard check.
module tb;
    import fsp_pkg::*;

    localparam int COUNT_BITS = 8;
    localparam int unsigned ACC_MAX = (1 << COUNT_BITS) - 1;

    typedef logic [7:0] t_char_q[$];

    class spec_scoreboard;
        t_out_word   awaited[$];
        int          fails;
        logic [1:0]  parse_st;
        logic        in_prec;
        logic        zflag;
        logic        err_hold;
        int unsigned width_acc;
        int unsigned prec_acc;

        function new();
            fails    = 0;
            parse_st = ST_TEXT;
            in_prec  = 0;
            zflag    = 0;
            err_hold = 0;
            width_acc = 0;
            prec_acc  = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function bit flag_error(inout t_out_word r, input logic [1:0] code);
            r.kind       = KIND_ERR;
            r.error_code = code;
            parse_st     = ST_TEXT;
            in_prec      = 0;
            err_hold     = !r.end_of_format;
            return 1'b1;
        endfunction

        function logic [7:0] clip_field(int unsigned v);
            return (v > FIELD_MAX) ? FIELD_MAX : v[7:0];
        endfunction

        // One character through the parser; returns 1 when it makes a result word.
        function bit parse_char(t_in_word w, output t_out_word r);
            logic [7:0]  c;
            bit          is_digit;
            bit          is_alpha;
            int unsigned v;
            c        = w.ch;
            is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
            is_alpha = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
            r               = '0;
            r.char_out      = c;
            r.end_of_format = w.last;

            // dropping characters until the end of the string
            if (err_hold) begin
                if (w.last) begin
                    err_hold = 0;
                    parse_st = ST_TEXT;
                    in_prec  = 0;
                end
                return 1'b0;
            end

            if (parse_st != ST_BEGIN && parse_st != ST_SPEC) begin
                parse_st = ST_TEXT;
                if (c == CH_PERCENT) begin
                    if (w.last)
                        return flag_error(r, ERR_PCT_END);
                    parse_st  = ST_BEGIN;
                    in_prec   = 0;
                    zflag     = 0;
                    width_acc = 0;
                    prec_acc  = 0;
                    return 1'b0;
                end
                r.kind = KIND_LIT;
                return 1'b1;
            end

            if (parse_st == ST_BEGIN) begin
                if (c == CH_PERCENT) begin
                    parse_st = ST_TEXT;
                    r.kind   = KIND_LIT;
                    return 1'b1;
                end
                // zero fill only counts right after the percent
                if (c == CH_ZERO) begin
                    zflag    = 1;
                    parse_st = ST_SPEC;
                    if (w.last)
                        return flag_error(r, ERR_UNTERM);
                    return 1'b0;
                end
            end

            parse_st = ST_SPEC;
            if (c == CH_DOT) begin
                in_prec = 1;
            end else if (is_digit) begin
                if (in_prec) begin
                    v = prec_acc * DEC_RADIX + (c - CH_ZERO);
                    prec_acc = (v > ACC_MAX) ? ACC_MAX : v;
                end else begin
                    v = width_acc * DEC_RADIX + (c - CH_ZERO);
                    width_acc = (v > ACC_MAX) ? ACC_MAX : v;
                end
            end else if (is_alpha) begin
                parse_st          = ST_TEXT;
                in_prec           = 0;
                r.kind            = KIND_SPEC;
                r.zero_fill       = zflag;
                r.field_width     = clip_field(width_acc);
                r.field_precision = clip_field(prec_acc);
                return 1'b1;
            end else begin
                return flag_error(r, ERR_BAD_CHAR);
            end
            if (w.last)
                return flag_error(r, ERR_UNTERM);
            return 1'b0;
        endfunction

        function void note_input(t_in_word w);
            t_out_word r;
            if (parse_char(w, r))
                awaited.push_back(r);
        endfunction

        function void cmp_field(string name, int unsigned e, int unsigned a);
            if (e != a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                fails++;
            end
        endfunction

        function void check_result(t_out_word got);
            t_out_word e;
            if (awaited.size() == 0) begin
                $error("unexpected result word: kind %0d char %02h", got.kind, got.char_out);
                fails++;
                return;
            end
            e = awaited.pop_front();
            cmp_field("kind", e.kind, got.kind);
            cmp_field("char_out", e.char_out, got.char_out);
            cmp_field("zero_fill", e.zero_fill, got.zero_fill);
            cmp_field("field_width", e.field_width, got.field_width);
            cmp_field("field_precision", e.field_precision, got.field_precision);
            cmp_field("error_code", e.error_code, got.error_code);
            cmp_field("end_of_format", e.end_of_format, got.end_of_format);
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;

    spec_scoreboard sb;
    int  sent;
    bit  quiet;

    format_spec_parser_core #(
        .COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // accepted words on both channels, sampled with pre-edge values
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_input(in_word);
            if (out_valid && !out_stall)
                sb.check_result(out_word);
        end
    end

    // receiver stalls in short bursts
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && !quiet && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic l);
        in_valid   <= 1'b1;
        in_word    <= '{ch: c, last: l};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic send_format(input t_char_q fmt);
        bit idle_on;
        idle_on = ($urandom_range(0, 2) != 0);
        for (int i = 0; i < fmt.size(); i++) begin
            send_char(fmt[i], i == fmt.size() - 1);
            if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
    endtask

    task automatic send_text(input string s);
        t_char_q q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        send_format(q);
    endtask

    task automatic drain_pause();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1))
            return 8'($urandom_range(CH_UP_A, CH_UP_Z));
        return 8'($urandom_range(CH_LO_A, CH_LO_Z));
    endfunction

    initial begin
        t_char_q    fmt;
        logic [7:0] c;
        int         n;
        bit         cut;

        sb       = new();
        sent     = 0;
        quiet    = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // extremes of ch, then a literal percent closing the string
        fmt = {8'h00, 8'hFF, CH_PERCENT, CH_PERCENT};
        send_format(fmt);
        send_text("%05.3d");
        // saturated width, repeated dot keeps the precision going
        send_text("%300.5.9f");
        send_text("%");
        // bad spec char, then the rest of the string is dropped
        send_text("%-ab");
        send_text("%10");
        send_text("%0");
        drain_pause();

        while (sent < 750) begin
            if (sent > 650)
                quiet = 1;
            fmt.delete();
            cut = 0;
            n = $urandom_range(1, 6);
            for (int p = 0; p < n && !cut; p++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        repeat ($urandom_range(1, 3)) begin
                            c = 8'($urandom_range(0, 255));
                            if (c == CH_PERCENT)
                                c = CH_LO_A;
                            fmt.push_back(c);
                        end
                    end
                    3: begin
                        fmt.push_back(CH_PERCENT);
                        fmt.push_back(CH_PERCENT);
                    end
                    8: begin
                        // percent followed by an arbitrary byte
                        fmt.push_back(CH_PERCENT);
                        fmt.push_back(8'($urandom_range(0, 255)));
                    end
                    9: begin
                        // spec cut off by the end of the string
                        fmt.push_back(CH_PERCENT);
                        if ($urandom_range(0, 1))
                            fmt.push_back(CH_ZERO);
                        repeat ($urandom_range(0, 2)) fmt.push_back(rand_digit());
                        if ($urandom_range(0, 1))
                            fmt.push_back(CH_DOT);
                        cut = 1;
                    end
                    default: begin
                        fmt.push_back(CH_PERCENT);
                        if ($urandom_range(0, 2) == 0)
                            fmt.push_back(CH_ZERO);
                        repeat ($urandom_range(0, 4)) fmt.push_back(rand_digit());
                        if ($urandom_range(0, 1)) begin
                            fmt.push_back(CH_DOT);
                            repeat ($urandom_range(0, 4)) fmt.push_back(rand_digit());
                            if ($urandom_range(0, 7) == 0) begin
                                fmt.push_back(CH_DOT);
                                fmt.push_back(rand_digit());
                            end
                        end
                        fmt.push_back(rand_letter());
                    end
                endcase
            end
            send_format(fmt);
            if (!quiet && $urandom_range(0, 99) == 0)
                drain_pause();
        end
        in_valid <= 1'b0;

        n = 0;
        while (sb.pending() != 0 && n < 5000) begin
            @(posedge clk);
            n++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending() != 0) begin
            $error("%0d expected result words never arrived", sb.pending());
            sb.fails++;
        end

        if (sb.fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/fsp_pkg.sv
rtl/core/fsp_step.sv
rtl/core/format_spec_parser_core.sv
rtl/core/fsp_checker.sv
tb/sv/tb.sv
